@@ rtl/rv32im_execute_unit_macros.svh @@
// assertion macros for the rv32im execute unit checker
// uses clk and arst_n of the module that includes it
`ifndef RV32IM_EXECUTE_UNIT_MACROS_SVH
`define RV32IM_EXECUTE_UNIT_MACROS_SVH

// checked only outside reset
`define RV_ASSERT(lbl, pexpr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pexpr) else $error(msg);

// checked during reset as well
`define RV_ASSERT_ALWAYS(lbl, pexpr, msg) \
	lbl: assert property (@(posedge clk) pexpr) else $error(msg);

`endif

@@ rtl/rv32_pkg.sv @@
// shared types and constants of the rv32im execute unit
// no dependencies
package rv32_pkg;
	localparam int REG_COUNT_DEF = 32;
	localparam logic [31:0] RESET_PC_DEF = 32'h8000_0000;

	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_REG    = 7'b0110011;
	localparam logic [6:0] OPC_IMM    = 7'b0010011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
	localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
	localparam logic [4:0] A0_IDX = 5'b01010;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MD   = 7'h01;
	localparam logic [6:0] F7_ALT  = 7'h20;

	localparam logic [1:0] TRAP_NONE  = 2'd0;
	localparam logic [1:0] TRAP_EBRK  = 2'd1;
	localparam logic [1:0] TRAP_ILL   = 2'd2;
	localparam logic [1:0] TRAP_SEQ   = 2'd3;

	localparam logic [1:0] MEM_NONE  = 2'd0;
	localparam logic [1:0] MEM_READ  = 2'd1;
	localparam logic [1:0] MEM_WRITE = 2'd2;

	localparam logic OP_EXEC = 1'b0;
	localparam logic OP_LOAD_RET = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic latch_in;
		logic rd_sel_a;
		logic cap_a;
		logic md_start;
		logic commit;
	} rv32_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic need_md;
		logic md_done;
		logic out_free;
	} rv32_status_t;
endpackage

@@ rtl/rv32im_execute_unit.sv @@
// top level of the rv32im execute unit
// depends on rv32_pkg, rv32_ctrl, rv32_dp (with rv32_ram, rv32_mdu)
//
// usage
//  - input channel (in_valid/in_stall): one word per item; op 0 carries the
//    instruction at the current pc, op 1 carries raw data for a pending load
//  - output channel (out_valid/out_stall): one result word per input word,
//    next pc, memory request, register update and trap code
//  - results: registered in the output register at commit; multiply and
//    divide ops first iterate in the one-bit-per-cycle shared unit
//  - a new item is accepted only after the previous one commits; the
//    register file is read through its single registered port, rs1 then rs2
//  - a finished result sits in the output register; the next word is
//    accepted meanwhile and the following result waits until it is taken
//  - apb port: reset_pc at byte address 0, pready always high
//  - reset: pc loads the reset value of reset_pc, no load pending, every
//    register reads zero (per-entry valid bits, no clearing pass)
//  - a stalled receiver holds the result stable and stops execution at the
//    commit point; architectural state changes only at commit
module rv32im_execute_unit import rv32_pkg::*; #(
	parameter int REG_COUNT = REG_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] instruction,
	input  logic [31:0] load_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic [1:0]  mem_request,
	output logic [31:0] mem_address,
	output logic [2:0]  mem_bytes,
	output logic [31:0] mem_write_data,
	output logic        reg_written,
	output logic [4:0]  reg_index,
	output logic [31:0] reg_value,
	output logic [1:0]  trap,
	output logic [31:0] trap_value
);
	rv32_cmd_t    cmd;
	rv32_status_t status;

	// zero wait state config access
	assign pready = 1'b1;

	// sequencer: latch, read rs1, read rs2, execute or iterate, commit
	rv32_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// register file, pc, decode, alu, mul/div unit and output register
	rv32_dp #(
		.REG_COUNT (REG_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.op             (op),
		.instruction    (instruction),
		.load_data      (load_data),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.next_pc        (next_pc),
		.mem_request    (mem_request),
		.mem_address    (mem_address),
		.mem_bytes      (mem_bytes),
		.mem_write_data (mem_write_data),
		.reg_written    (reg_written),
		.reg_index      (reg_index),
		.reg_value      (reg_value),
		.trap           (trap),
		.trap_value     (trap_value)
	);
endmodule

@@ rtl/rv32_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module rv32_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/rv32_mdu.sv @@
// iterative shift-add multiplier and restoring divider on magnitudes
// one bit per cycle; no dependencies
module rv32_mdu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        is_div,
	input  logic [31:0] a_mag,
	input  logic [31:0] b_mag,
	output logic        done,
	output logic [31:0] hi,
	output logic [31:0] lo
);
	logic        busy_q;
	logic        done_q;
	logic        div_q;
	logic [4:0]  cnt_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [31:0] b_q;
	logic [32:0] sum;
	logic [32:0] shifted;
	logic [33:0] diff;

	assign sum     = {1'b0, hi_q} + {1'b0, b_q};
	assign shifted = {hi_q, lo_q[31]};
	assign diff    = {1'b0, shifted} - {2'b00, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			hi_q  <= '0;
			lo_q  <= a_mag;
			b_q   <= b_mag;
		end else if (busy_q) begin
			if (div_q) begin
				// restoring step: keep the difference when no borrow
				if (!diff[33]) begin
					hi_q <= diff[31:0];
					lo_q <= {lo_q[30:0], 1'b1};
				end else begin
					hi_q <= shifted[31:0];
					lo_q <= {lo_q[30:0], 1'b0};
				end
			end else if (lo_q[0]) begin
				hi_q <= sum[32:1];
				lo_q <= {sum[0], lo_q[31:1]};
			end else begin
				hi_q <= hi_q >> 1;
				lo_q <= {hi_q[0], lo_q[31:1]};
			end
		end
	end

	assign done = done_q;
	assign hi   = hi_q;
	assign lo   = lo_q;
endmodule

@@ rtl/rv32_ctrl.sv @@
// controller state machine of the rv32im execute unit
// depends on rv32_pkg
module rv32_ctrl import rv32_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  rv32_status_t status,
	output rv32_cmd_t    cmd
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RDA  = 6'b000010,
		S_RDB  = 6'b000100,
		S_EXEC = 6'b001000,
		S_MD   = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = S_RDA;
				end
			end
			S_RDA: begin
				cmd.rd_sel_a = 1'b1;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.cap_a = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (status.need_md) begin
					cmd.md_start = 1'b1;
					state_d = S_MD;
				end else if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_MD: begin
				if (status.md_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ rtl/rv32_dp.sv @@
// datapath: register file, pc, decode, alu, load return and output register
// depends on rv32_pkg, rv32_ram, rv32_mdu
module rv32_dp import rv32_pkg::*; #(
	parameter int REG_COUNT = REG_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  rv32_cmd_t    cmd,
	output rv32_status_t status,
	input  logic         op,
	input  logic [31:0]  instruction,
	input  logic [31:0]  load_data,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [31:0]  next_pc,
	output logic [1:0]   mem_request,
	output logic [31:0]  mem_address,
	output logic [2:0]   mem_bytes,
	output logic [31:0]  mem_write_data,
	output logic         reg_written,
	output logic [4:0]   reg_index,
	output logic [31:0]  reg_value,
	output logic [1:0]   trap,
	output logic [31:0]  trap_value
);
	localparam int AW = $clog2(REG_COUNT);

	logic                 op_q;
	logic [31:0]          inst_q;
	logic [31:0]          ld_q;
	logic [31:0]          a_q;
	logic [31:0]          pc_q;
	logic [31:0]          reset_pc_q;
	logic                 pend_q;
	logic [4:0]           pdest_q;
	logic [2:0]           pkind_q;
	logic [REG_COUNT-1:0] vld_q;
	logic                 out_valid_q;

	logic [4:0]    rsa;
	logic [4:0]    rs2;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;
	logic [31:0]   b;
	logic          ram_we;

	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [4:0]  rd;
	logic [31:0] immi;
	logic [31:0] imms;
	logic [31:0] immb;
	logic [31:0] immj;
	logic [31:0] immu;

	logic        x_md;
	logic [31:0] x_next;
	logic [1:0]  x_trap;
	logic [31:0] x_tv;
	logic        x_wr;
	logic [4:0]  x_idx;
	logic [31:0] x_val;
	logic [1:0]  x_req;
	logic [31:0] x_addr;
	logic [2:0]  x_bytes;
	logic [31:0] x_wdata;
	logic        x_ld;
	logic        x_clr_pend;
	logic        x_take;
	logic        x_commit_wr;

	logic        sa;
	logic        sb;
	logic [31:0] a_mag;
	logic [31:0] b_mag;
	logic        md_done;
	logic [31:0] md_hi;
	logic [31:0] md_lo;
	logic [63:0] prod;
	logic [31:0] md_val;

	function automatic logic reg_ok(logic [4:0] idx, logic [REG_COUNT-1:0] vld);
		reg_ok = (idx != 5'd0) && (32'(idx) < REG_COUNT) && vld[idx[AW-1:0]];
	endfunction

	assign rsa   = (inst_q == EBREAK_WORD) ? A0_IDX : inst_q[19:15];
	assign rs2   = inst_q[24:20];
	assign raddr = cmd.rd_sel_a ? rsa[AW-1:0] : rs2[AW-1:0];
	assign b     = reg_ok(rs2, vld_q) ? rdata : 32'd0;

	assign opc  = inst_q[6:0];
	assign f3   = inst_q[14:12];
	assign f7   = inst_q[31:25];
	assign rd   = inst_q[11:7];
	assign immi = {{20{inst_q[31]}}, inst_q[31:20]};
	assign imms = {{20{inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
	assign immb = {{19{inst_q[31]}}, inst_q[31], inst_q[7], inst_q[30:25], inst_q[11:8], 1'b0};
	assign immj = {{11{inst_q[31]}}, inst_q[31], inst_q[19:12], inst_q[20], inst_q[30:21],
		1'b0};
	assign immu = {inst_q[31:12], 12'd0};

	// operand signs for the multiply and divide ops
	assign sa    = a_q[31] && (f3 == 3'd1 || f3 == 3'd2 || f3 == 3'd4 || f3 == 3'd6);
	assign sb    = b[31] && (f3 == 3'd1 || f3 == 3'd4 || f3 == 3'd6);
	assign a_mag = sa ? (32'd0 - a_q) : a_q;
	assign b_mag = sb ? (32'd0 - b) : b;
	assign prod  = (sa ^ sb) ? (64'd0 - {md_hi, md_lo}) : {md_hi, md_lo};

	always_comb begin
		case (f3)
			3'd0:    md_val = prod[31:0];
			3'd1,
			3'd2,
			3'd3:    md_val = prod[63:32];
			3'd4:    md_val = ((sa ^ sb) && b != 32'd0) ? (32'd0 - md_lo) : md_lo;
			3'd5:    md_val = md_lo;
			3'd6:    md_val = sa ? (32'd0 - md_hi) : md_hi;
			default: md_val = md_hi;
		endcase
	end

	rv32_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.md_start),
		.is_div (f3[2]),
		.a_mag  (a_mag),
		.b_mag  (b_mag),
		.done   (md_done),
		.hi     (md_hi),
		.lo     (md_lo)
	);

	// decode and execute of the latched word
	always_comb begin
		x_md       = 1'b0;
		x_next     = pc_q + 32'd4;
		x_trap     = TRAP_NONE;
		x_tv       = 32'd0;
		x_wr       = 1'b0;
		x_idx      = rd;
		x_val      = 32'd0;
		x_req      = MEM_NONE;
		x_addr     = 32'd0;
		x_bytes    = 3'd0;
		x_wdata    = 32'd0;
		x_ld       = 1'b0;
		x_clr_pend = 1'b0;
		x_take     = 1'b0;
		if (op_q == OP_LOAD_RET) begin
			x_next = pc_q;
			if (!pend_q) begin
				x_trap = TRAP_SEQ;
			end else begin
				x_wr       = 1'b1;
				x_idx      = pdest_q;
				x_clr_pend = 1'b1;
				case (pkind_q)
					3'd0:    x_val = {{24{ld_q[7]}}, ld_q[7:0]};
					3'd1:    x_val = {{16{ld_q[15]}}, ld_q[15:0]};
					3'd4:    x_val = {24'd0, ld_q[7:0]};
					3'd5:    x_val = {16'd0, ld_q[15:0]};
					default: x_val = ld_q;
				endcase
			end
		end else if (pend_q) begin
			x_trap = TRAP_SEQ;
		end else begin
			case (opc)
				OPC_LUI: begin
					x_wr  = 1'b1;
					x_val = immu;
				end
				OPC_AUIPC: begin
					x_wr  = 1'b1;
					x_val = pc_q + immu;
				end
				OPC_JAL: begin
					x_wr   = 1'b1;
					x_val  = pc_q + 32'd4;
					x_next = pc_q + immj;
				end
				OPC_JALR: begin
					if (f3 != 3'd0) begin
						x_trap = TRAP_ILL;
					end else begin
						x_wr   = 1'b1;
						x_val  = pc_q + 32'd4;
						x_next = (a_q + immi) & ~32'd1;
					end
				end
				OPC_BRANCH: begin
					case (f3)
						3'd0:    x_take = (a_q == b);
						3'd1:    x_take = (a_q != b);
						3'd4:    x_take = $signed(a_q) < $signed(b);
						3'd5:    x_take = $signed(a_q) >= $signed(b);
						3'd6:    x_take = a_q < b;
						3'd7:    x_take = a_q >= b;
						default: x_trap = TRAP_ILL;
					endcase
					if (x_take) begin
						x_next = pc_q + immb;
					end
				end
				OPC_REG: begin
					x_wr = 1'b1;
					if (f7 == F7_MD) begin
						x_md  = 1'b1;
						x_val = md_val;
					end else if (f7 == F7_ALT) begin
						if (f3 == 3'd0) begin
							x_val = a_q - b;
						end else if (f3 == 3'd5) begin
							x_val = 32'($signed(a_q) >>> b[4:0]);
						end else begin
							x_trap = TRAP_ILL;
						end
					end else if (f7 != F7_BASE) begin
						x_trap = TRAP_ILL;
					end else begin
						case (f3)
							3'd0:    x_val = a_q + b;
							3'd1:    x_val = a_q << b[4:0];
							3'd2:    x_val = {31'd0, $signed(a_q) < $signed(b)};
							3'd3:    x_val = {31'd0, a_q < b};
							3'd4:    x_val = a_q ^ b;
							3'd5:    x_val = a_q >> b[4:0];
							3'd6:    x_val = a_q | b;
							default: x_val = a_q & b;
						endcase
					end
				end
				OPC_IMM: begin
					x_wr = 1'b1;
					case (f3)
						3'd0: x_val = a_q + immi;
						3'd1: begin
							x_val = a_q << immi[4:0];
							if (f7 != F7_BASE) x_trap = TRAP_ILL;
						end
						3'd2: x_val = {31'd0, $signed(a_q) < $signed(immi)};
						3'd3: x_val = {31'd0, a_q < immi};
						3'd4: x_val = a_q ^ immi;
						3'd5: begin
							if (f7 == F7_BASE) begin
								x_val = a_q >> immi[4:0];
							end else if (f7 == F7_ALT) begin
								x_val = 32'($signed(a_q) >>> immi[4:0]);
							end else begin
								x_trap = TRAP_ILL;
							end
						end
						3'd6:    x_val = a_q | immi;
						default: x_val = a_q & immi;
					endcase
				end
				OPC_STORE: begin
					if (f3 > 3'd2) begin
						x_trap = TRAP_ILL;
					end else begin
						x_req   = MEM_WRITE;
						x_addr  = a_q + imms;
						x_bytes = 3'd1 << f3[1:0];
						x_wdata = b;
					end
				end
				OPC_LOAD: begin
					if (f3 == 3'd3 || f3 > 3'd5) begin
						x_trap = TRAP_ILL;
					end else begin
						x_req   = MEM_READ;
						x_addr  = a_q + immi;
						x_bytes = 3'd1 << f3[1:0];
						x_ld    = 1'b1;
					end
				end
				OPC_SYSTEM: begin
					if (inst_q == EBREAK_WORD) begin
						x_trap = TRAP_EBRK;
						x_tv   = a_q;
					end else begin
						x_trap = TRAP_ILL;
					end
				end
				default: x_trap = TRAP_ILL;
			endcase
		end
	end

	assign x_commit_wr = (x_trap == TRAP_NONE) && x_wr && (x_idx != 5'd0) &&
		(32'(x_idx) < REG_COUNT);
	assign ram_we = cmd.commit && x_commit_wr;

	rv32_ram #(
		.WIDTH (32),
		.DEPTH (REG_COUNT)
	) u_rf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (x_idx[AW-1:0]),
		.wdata (x_val),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign status.need_md  = x_md && (x_trap == TRAP_NONE);
	assign status.md_done  = md_done;
	assign status.out_free = !out_valid_q || !out_stall;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= RESET_PC_DEF;
			reset_pc_q  <= RESET_PC_DEF;
			pend_q      <= 1'b0;
			pdest_q     <= '0;
			pkind_q     <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == 3'd0) begin
				reset_pc_q <= pwdata;
			end
			if (out_valid_q && !out_stall && !cmd.commit) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (x_trap == TRAP_NONE) begin
					pc_q <= x_next;
					if (x_ld) begin
						pend_q  <= 1'b1;
						pdest_q <= rd;
						pkind_q <= f3;
					end else if (x_clr_pend) begin
						pend_q <= 1'b0;
					end
				end
				if (ram_we) begin
					vld_q[x_idx[AW-1:0]] <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= op;
			inst_q <= instruction;
			ld_q   <= load_data;
		end
		if (cmd.cap_a) begin
			a_q <= reg_ok(rsa, vld_q) ? rdata : 32'd0;
		end
		if (cmd.commit) begin
			trap       <= x_trap;
			trap_value <= x_tv;
			if (x_trap != TRAP_NONE) begin
				next_pc        <= pc_q;
				mem_request    <= MEM_NONE;
				mem_address    <= 32'd0;
				mem_bytes      <= 3'd0;
				mem_write_data <= 32'd0;
				reg_written    <= 1'b0;
				reg_index      <= 5'd0;
				reg_value      <= 32'd0;
			end else begin
				next_pc        <= x_next;
				mem_request    <= x_req;
				mem_address    <= x_addr;
				mem_bytes      <= x_bytes;
				mem_write_data <= x_wdata;
				reg_written    <= x_commit_wr;
				reg_index      <= x_commit_wr ? x_idx : 5'd0;
				reg_value      <= x_commit_wr ? x_val : 32'd0;
			end
		end
	end

	assign prdata    = (paddr == 3'd0) ? reset_pc_q : 32'd0;
	assign out_valid = out_valid_q;
endmodule

@@ rtl/rv32_chk.sv @@
// port level checker for the rv32im execute unit, bound to the top level
// depends on rv32_pkg and rv32im_execute_unit_macros.svh
`include "rv32im_execute_unit_macros.svh"
module rv32_chk import rv32_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] next_pc,
	input logic [1:0]  mem_request,
	input logic [2:0]  mem_bytes,
	input logic        reg_written,
	input logic [4:0]  reg_index,
	input logic [1:0]  trap
);
	// a stalled result holds
	`RV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(next_pc), "stall lost")
	// a trapped word neither writes nor touches memory
	`RV_ASSERT(a_trap_quiet, out_valid && trap != TRAP_NONE |-> mem_request == MEM_NONE && !reg_written, "trap")
	// x0 is never reported as written
	`RV_ASSERT(a_no_x0, out_valid && reg_written |-> reg_index != 5'd0, "write to x0 reported")
	// size is zero exactly when there is no request
	`RV_ASSERT(a_bytes, !out_valid || ((mem_request == MEM_NONE) == (mem_bytes == 3'd0)), "size")
endmodule

bind rv32im_execute_unit rv32_chk u_chk (.*);
